// ===== rtl/core/ppb_pkg.sv =====
// ----------------------------------------------------------------------------
// ppb_pkg
// Shared types, constants and saturation helpers for the plane pixel
// back-projection datapath.
// ----------------------------------------------------------------------------
package ppb_pkg;

  localparam int Q_W      = 40;   // signed Q.20 intermediate width
  localparam int POSE_W   = 21;   // signed Q10.10 pose word
  localparam int FOC_W    = 31;   // unsigned Q11.20 intrinsics
  localparam int HALF_W   = 20;   // unsigned Q12.8 half extents
  localparam int TPU_W    = 24;   // unsigned Q8.16 texel scale
  localparam int COORD_W  = 11;   // pixel coordinate
  localparam int PLANE_W  = 21;   // signed Q12.8 plane coordinate
  localparam int TEX_W    = 10;   // texel index
  localparam int DIST_W   = 41;   // signed texel distance, Q.20
  localparam int APB_AW   = 6;
  localparam int APB_DW   = 64;

  localparam int TEXTURE_DIM_DEF = 1024;
  localparam int IMAGE_DIM_DEF   = 2048;

  localparam logic signed [Q_W-1:0] Q40_MAX = {1'b0, {(Q_W-1){1'b1}}};
  localparam logic signed [Q_W-1:0] Q40_MIN = {1'b1, {(Q_W-1){1'b0}}};

  typedef logic signed [Q_W-1:0] q40_t;

  typedef enum logic [2:0] {
    REG_ROW_X,
    REG_ROW_Y,
    REG_ROW_W,
    REG_FOCAL,
    REG_PRINCIPAL,
    REG_HALF_W,
    REG_HALF_H,
    REG_TPU
  } reg_idx_e;

  typedef struct packed {
    logic signed [POSE_W-1:0] r00;
    logic signed [POSE_W-1:0] r01;
    logic signed [POSE_W-1:0] tx;
    logic signed [POSE_W-1:0] r10;
    logic signed [POSE_W-1:0] r11;
    logic signed [POSE_W-1:0] ty;
    logic signed [POSE_W-1:0] r20;
    logic signed [POSE_W-1:0] r21;
    logic signed [POSE_W-1:0] tz;
    logic [FOC_W-1:0]         fx;
    logic [FOC_W-1:0]         fy;
    logic [FOC_W-1:0]         cx;
    logic [FOC_W-1:0]         cy;
    logic [HALF_W-1:0]        hw;
    logic [HALF_W-1:0]        hh;
    logic [TPU_W-1:0]         tpu;
  } cfg_t;

  // clamp a wide signed value to the 40-bit intermediate range
  function automatic q40_t sat40(input logic signed [63:0] x);
    if (x > 64'(Q40_MAX)) return Q40_MAX;
    if (x < 64'(Q40_MIN)) return Q40_MIN;
    return x[Q_W-1:0];
  endfunction

  // apply sign to a divider magnitude and saturate
  function automatic q40_t div_fix(input logic neg, input logic [Q_W-1:0] q,
                                   input logic ovf);
    if (ovf) return neg ? Q40_MIN : Q40_MAX;
    if (!neg) return q[Q_W-1] ? Q40_MAX : $signed(q);
    if (q[Q_W-1] && (|q[Q_W-2:0])) return Q40_MIN;
    return $signed(-q);
  endfunction

endpackage

// ===== rtl/core/ppb_regs.sv =====
// ----------------------------------------------------------------------------
// ppb_regs
// APB register file holding the pose, intrinsics and patch settings.
// ----------------------------------------------------------------------------
module ppb_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ppb_pkg::APB_AW-1:0] paddr,
  input  logic [ppb_pkg::APB_DW-1:0] pwdata,
  output logic [ppb_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  output ppb_pkg::cfg_t              cfg_o
);
  import ppb_pkg::*;

  logic [62:0]       row_x_q, row_y_q, row_w_q;
  logic [61:0]       focal_q, princ_q;
  logic [HALF_W-1:0] hw_q, hh_q;
  logic [TPU_W-1:0]  tpu_q;
  logic              wr_en;
  reg_idx_e          idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_x_q <= '0;
      row_y_q <= '0;
      row_w_q <= '0;
      focal_q <= '0;
      princ_q <= '0;
      hw_q    <= HALF_W'(32000);
      hh_q    <= HALF_W'(32000);
      tpu_q   <= TPU_W'(65536);
    end else if (wr_en) begin
      unique case (idx)
        REG_ROW_X:     row_x_q <= pwdata[62:0];
        REG_ROW_Y:     row_y_q <= pwdata[62:0];
        REG_ROW_W:     row_w_q <= pwdata[62:0];
        REG_FOCAL:     focal_q <= pwdata[61:0];
        REG_PRINCIPAL: princ_q <= pwdata[61:0];
        REG_HALF_W:    hw_q    <= pwdata[HALF_W-1:0];
        REG_HALF_H:    hh_q    <= pwdata[HALF_W-1:0];
        REG_TPU:       tpu_q   <= pwdata[TPU_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ROW_X:     prdata = {1'b0, row_x_q};
      REG_ROW_Y:     prdata = {1'b0, row_y_q};
      REG_ROW_W:     prdata = {1'b0, row_w_q};
      REG_FOCAL:     prdata = {2'b0, focal_q};
      REG_PRINCIPAL: prdata = {2'b0, princ_q};
      REG_HALF_W:    prdata = {44'b0, hw_q};
      REG_HALF_H:    prdata = {44'b0, hh_q};
      REG_TPU:       prdata = {40'b0, tpu_q};
    endcase
  end

  always_comb begin
    cfg_o.r00 = $signed(row_x_q[62:42]);
    cfg_o.r01 = $signed(row_x_q[41:21]);
    cfg_o.tx  = $signed(row_x_q[20:0]);
    cfg_o.r10 = $signed(row_y_q[62:42]);
    cfg_o.r11 = $signed(row_y_q[41:21]);
    cfg_o.ty  = $signed(row_y_q[20:0]);
    cfg_o.r20 = $signed(row_w_q[62:42]);
    cfg_o.r21 = $signed(row_w_q[41:21]);
    cfg_o.tz  = $signed(row_w_q[20:0]);
    cfg_o.fx  = focal_q[61:31];
    cfg_o.fy  = focal_q[30:0];
    cfg_o.cx  = princ_q[61:31];
    cfg_o.cy  = princ_q[30:0];
    cfg_o.hw  = hw_q;
    cfg_o.hh  = hh_q;
    cfg_o.tpu = tpu_q;
  end

endmodule

// ===== rtl/core/ppb_div.sv =====
// ----------------------------------------------------------------------------
// ppb_div
// Pipelined restoring divider: one quotient bit per stage, 40-bit quotient
// with an overflow flag, side data carried along with each request.
// ----------------------------------------------------------------------------
module ppb_div #(
  parameter int NW = 60,
  parameter int DW = 40,
  parameter int SW = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic [NW-1:0]           num_i,
  input  logic [DW-1:0]           den_i,
  input  logic [SW-1:0]           side_i,
  output logic                    vld_o,
  output logic [ppb_pkg::Q_W-1:0] quo_o,
  output logic                    ovf_o,
  output logic [SW-1:0]           side_o
);
  import ppb_pkg::*;

  logic           vld_q  [0:Q_W];
  logic [DW-1:0]  rem_q  [0:Q_W];
  logic [Q_W-1:0] lo_q   [0:Q_W-1];
  logic [Q_W-1:0] quo_q  [0:Q_W];
  logic [DW-1:0]  den_q  [0:Q_W];
  logic           ovf_q  [0:Q_W];
  logic [SW-1:0]  side_q [0:Q_W];

  // quotient of 2^40 or more saturates; otherwise the top bits start below den
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= DW'(num_i[NW-1:Q_W]);
      lo_q[0]   <= num_i[Q_W-1:0];
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      ovf_q[0]  <= DW'(num_i[NW-1:Q_W]) >= den_i;
      side_q[0] <= side_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  for (genvar k = 0; k < Q_W; k++) begin : gen_stage
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        take;

    always_comb begin
      trial = {rem_q[k], lo_q[k][Q_W-1]};
      diff  = trial - {1'b0, den_q[k]};
      take  = trial >= {1'b0, den_q[k]};
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= take ? diff[DW-1:0] : trial[DW-1:0];
        quo_q[k+1]  <= {quo_q[k][Q_W-2:0], take};
        den_q[k+1]  <= den_q[k];
        ovf_q[k+1]  <= ovf_q[k];
        side_q[k+1] <= side_q[k];
      end
    end

    if (k < Q_W-1) begin : gen_lo
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          lo_q[k+1] <= lo_q[k] << 1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end
  end

  assign vld_o  = vld_q[Q_W];
  assign quo_o  = quo_q[Q_W];
  assign ovf_o  = ovf_q[Q_W];
  assign side_o = side_q[Q_W];

endmodule

// ===== rtl/core/ppb_texel.sv =====
// ----------------------------------------------------------------------------
// ppb_texel
// Two-stage scale of a plane distance into a clamped texel index.
// ----------------------------------------------------------------------------
module ppb_texel #(
  parameter int TEXTURE_DIM = ppb_pkg::TEXTURE_DIM_DEF
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [ppb_pkg::DIST_W-1:0] dist_i,
  input  logic [ppb_pkg::TPU_W-1:0]         tpu_i,
  output logic [ppb_pkg::TEX_W-1:0]         texel_o
);
  import ppb_pkg::*;

  localparam int LIM = (TEXTURE_DIM - 1 < 1023) ? TEXTURE_DIM - 1 : 1023;

  logic        pos_q;
  logic [43:0] ph_q, pl_q;
  logic [44:0] sum;
  logic [28:0] quo;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_q <= dist_i > 0;
      ph_q  <= 44'(dist_i[39:20]) * 44'(tpu_i);
      pl_q  <= 44'(dist_i[19:0]) * 44'(tpu_i);
    end
  end

  always_comb begin
    sum = 45'(ph_q) + 45'(pl_q >> 20);
    quo = sum[44:16];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!pos_q) begin
        texel_o <= '0;
      end else if (quo > 29'(LIM)) begin
        texel_o <= TEX_W'(LIM);
      end else begin
        texel_o <= quo[TEX_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/plane_pixel_backprojection.sv =====
// ----------------------------------------------------------------------------
// plane_pixel_backprojection
// Back-projects a camera pixel onto the marker plane and maps it to a texel.
//
//   channel  direction  handshake             payload
//   pixel    in         in_valid_i/in_ready_o pixel_col_i, pixel_row_i
//   result   out        out_valid_o/out_ready_i plane_x_o, plane_y_o,
//                                             inside_patch_o, texel_row_o,
//                                             texel_col_o, degenerate_o
//   config   in/out     APB psel/penable      paddr, pwdata, prdata
//
// One request per cycle unless the output stalls; three bit-per-stage
// 41-stage dividers (normalize, plane Y, plane X) sit among 19 math stages.
// Reset clears every stage valid bit; no clearing pass.
// Stall: a waiting result freezes the whole pipeline in place; nothing is
// lost or repeated.
// ----------------------------------------------------------------------------
module plane_pixel_backprojection #(
  parameter int TEXTURE_DIM = ppb_pkg::TEXTURE_DIM_DEF,
  parameter int IMAGE_DIM   = ppb_pkg::IMAGE_DIM_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [ppb_pkg::COORD_W-1:0]        pixel_col_i,
  input  logic [ppb_pkg::COORD_W-1:0]        pixel_row_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [ppb_pkg::PLANE_W-1:0] plane_x_o,
  output logic signed [ppb_pkg::PLANE_W-1:0] plane_y_o,
  output logic                               inside_patch_o,
  output logic [ppb_pkg::TEX_W-1:0]          texel_row_o,
  output logic [ppb_pkg::TEX_W-1:0]          texel_col_o,
  output logic                               degenerate_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ppb_pkg::APB_AW-1:0]         paddr,
  input  logic [ppb_pkg::APB_DW-1:0]         pwdata,
  output logic [ppb_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);
  import ppb_pkg::*;

  localparam int LIM = (TEXTURE_DIM - 1 < 1023) ? TEXTURE_DIM - 1 : 1023;

  function automatic logic signed [PLANE_W-1:0] trunc_plane(input q40_t v);
    logic signed [40:0] t;
    logic signed [28:0] s;
    t = 41'(v) + (v[Q_W-1] ? 41'sd4095 : 41'sd0);
    s = 29'(t >>> 12);
    if (s > 29'sd1048575) return 21'sd1048575;
    if (s < -29'sd1048576) return -21'sd1048576;
    return s[PLANE_W-1:0];
  endfunction

  cfg_t cfg;
  logic adv;

  ppb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // ---------------- stage 1: centre and take magnitudes
  logic signed [32:0] du, dv;
  logic               inimg;
  logic               s1_vld_q, s1_su_q, s1_sv_q, s1_in_q;
  logic [31:0]        s1_mu_q, s1_mv_q;

  always_comb begin
    du    = $signed({2'b0, pixel_col_i, 20'b0}) - $signed({2'b0, cfg.cx});
    dv    = $signed({2'b0, pixel_row_i, 20'b0}) - $signed({2'b0, cfg.cy});
    inimg = ({21'b0, pixel_col_i} < 32'(IMAGE_DIM)) &&
            ({21'b0, pixel_row_i} < 32'(IMAGE_DIM));
  end

  // ---------------- normalize dividers
  logic              dvu_vld, dvu_ovf, dvv_ovf;
  logic [Q_W-1:0]    dvu_quo, dvv_quo;
  logic [1:0]        dvu_side;
  logic              dvv_side;

  ppb_div #(.NW(52), .DW(FOC_W), .SW(2)) u_div_u (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s1_vld_q),
    .num_i  ({s1_mu_q, 20'b0}),
    .den_i  (cfg.fx),
    .side_i ({s1_su_q, s1_in_q}),
    .vld_o  (dvu_vld),
    .quo_o  (dvu_quo),
    .ovf_o  (dvu_ovf),
    .side_o (dvu_side)
  );

  ppb_div #(.NW(52), .DW(FOC_W), .SW(1)) u_div_v (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s1_vld_q),
    .num_i  ({s1_mv_q, 20'b0}),
    .den_i  (cfg.fy),
    .side_i (s1_sv_q),
    .vld_o  (),
    .quo_o  (dvv_quo),
    .ovf_o  (dvv_ovf),
    .side_o (dvv_side)
  );

  // ---------------- stages 2..10: plane line coefficients and Y terms
  logic               s2_vld_q, s2_in_q;
  q40_t               s2_uu_q, s2_vv_q;
  logic               s3_vld_q, s3_in_q;
  q40_t               s3_uu_q;
  logic signed [60:0] s3_p0_q, s3_p1_q, s3_p2_q, s3_p3_q, s3_p4_q, s3_p5_q;
  logic               s4_vld_q, s4_in_q;
  q40_t               s4_uu_q, s4_a_q, s4_b_q, s4_c_q;
  logic               s5_vld_q, s5_in_q;
  q40_t               s5_uu_q, s5_a_q, s5_b_q, s5_c_q;
  logic signed [60:0] s5_p0_q, s5_p1_q, s5_p2_q, s5_p3_q;
  logic signed [60:0] s5_p4_q, s5_p5_q, s5_p6_q, s5_p7_q;
  logic               s6_vld_q, s6_in_q;
  q40_t               s6_uu_q, s6_a_q, s6_b_q, s6_c_q, s6_t1_q, s6_d1_q, s6_d2_q;
  logic signed [52:0] s6_pn_q;
  logic               s7_vld_q, s7_in_q;
  q40_t               s7_a_q, s7_b_q, s7_c_q, s7_d1_q;
  logic signed [52:0] s7_pn_q;
  logic signed [59:0] s7_h1_q, s7_h2_q;
  logic signed [60:0] s7_l1_q, s7_l2_q;
  logic               s8_vld_q, s8_in_q;
  q40_t               s8_a_q, s8_b_q, s8_c_q, s8_d1_q, s8_m1_q, s8_m2_q;
  logic signed [52:0] s8_pn_q;
  logic               s9_vld_q, s9_in_q;
  q40_t               s9_a_q, s9_b_q, s9_c_q, s9_num_q, s9_den_q;
  logic               s10_vld_q, s10_in_q, s10_dg_q, s10_sy_q;
  q40_t               s10_a_q, s10_b_q, s10_c_q;
  logic [Q_W-1:0]     s10_mn_q, s10_md_q;

  logic               fzero;
  assign fzero = (cfg.fx == '0) || (cfg.fy == '0);

  // ---------------- plane Y divider
  logic              dvy_vld, dvy_ovf;
  logic [Q_W-1:0]    dvy_quo;
  logic [122:0]      dvy_side;

  ppb_div #(.NW(60), .DW(Q_W), .SW(123)) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s10_vld_q),
    .num_i  ({s10_mn_q, 20'b0}),
    .den_i  (s10_md_q),
    .side_i ({s10_sy_q, s10_dg_q, s10_in_q, s10_a_q, s10_b_q, s10_c_q}),
    .vld_o  (dvy_vld),
    .quo_o  (dvy_quo),
    .ovf_o  (dvy_ovf),
    .side_o (dvy_side)
  );

  // ---------------- stages 11..15: X numerator
  logic               s11_vld_q, s11_in_q, s11_dg_q;
  q40_t               s11_y_q, s11_a_q, s11_b_q, s11_c_q;
  logic               s12_vld_q, s12_in_q, s12_dg_q;
  q40_t               s12_y_q, s12_a_q, s12_c_q;
  logic signed [59:0] s12_h_q;
  logic signed [60:0] s12_l_q;
  logic               s13_vld_q, s13_in_q, s13_dg_q;
  q40_t               s13_y_q, s13_a_q, s13_c_q;
  logic signed [60:0] s13_m_q;
  logic               s14_vld_q, s14_in_q, s14_dg_q;
  q40_t               s14_y_q, s14_a_q, s14_e_q;
  logic               s15_vld_q, s15_in_q, s15_dg_q, s15_sx_q;
  q40_t               s15_y_q;
  logic [Q_W-1:0]     s15_me_q, s15_ma_q;

  // ---------------- plane X divider
  logic              dvx_vld, dvx_ovf;
  logic [Q_W-1:0]    dvx_quo;
  logic [42:0]       dvx_side;

  ppb_div #(.NW(60), .DW(Q_W), .SW(43)) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .vld_i  (s15_vld_q),
    .num_i  ({s15_me_q, 20'b0}),
    .den_i  (s15_ma_q),
    .side_i ({s15_sx_q, s15_dg_q, s15_in_q, s15_y_q}),
    .vld_o  (dvx_vld),
    .quo_o  (dvx_quo),
    .ovf_o  (dvx_ovf),
    .side_o (dvx_side)
  );

  // ---------------- stages 16..19: patch test, texel mapping, output
  logic                      s16_vld_q, s16_in_q, s16_dg_q;
  q40_t                      s16_x_q, s16_y_q;
  logic                      s17_vld_q, s17_dg_q, s17_ins_q;
  logic signed [DIST_W-1:0]  s17_dr_q, s17_dc_q;
  logic signed [PLANE_W-1:0] s17_px_q, s17_py_q;
  logic                      s18_vld_q, s18_dg_q, s18_ins_q;
  logic signed [PLANE_W-1:0] s18_px_q, s18_py_q;
  logic                      s19_vld_q, s19_dg_q, s19_ins_q;
  logic signed [PLANE_W-1:0] s19_px_q, s19_py_q;
  logic [TEX_W-1:0]          tex_row, tex_col;

  logic signed [DIST_W-1:0] hw20, hh20, x41, y41;
  always_comb begin
    hw20 = $signed({9'b0, cfg.hw, 12'b0});
    hh20 = $signed({9'b0, cfg.hh, 12'b0});
    x41  = DIST_W'(s16_x_q);
    y41  = DIST_W'(s16_y_q);
  end

  ppb_texel #(.TEXTURE_DIM(TEXTURE_DIM)) u_tex_row (
    .clk_i   (clk_i),
    .en_i    (adv),
    .dist_i  (s17_dr_q),
    .tpu_i   (cfg.tpu),
    .texel_o (tex_row)
  );

  ppb_texel #(.TEXTURE_DIM(TEXTURE_DIM)) u_tex_col (
    .clk_i   (clk_i),
    .en_i    (adv),
    .dist_i  (s17_dc_q),
    .tpu_i   (cfg.tpu),
    .texel_o (tex_col)
  );

  // advance everything unless the finished result is still waiting
  assign adv        = !s19_vld_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_su_q <= du[32];
      s1_sv_q <= dv[32];
      s1_mu_q <= du[32] ? 32'(-du) : 32'(du);
      s1_mv_q <= dv[32] ? 32'(-dv) : 32'(dv);
      s1_in_q <= inimg;

      s2_uu_q <= div_fix(dvu_side[1], dvu_quo, dvu_ovf);
      s2_vv_q <= div_fix(dvv_side, dvv_quo, dvv_ovf);
      s2_in_q <= dvu_side[0];

      s3_p0_q <= 61'(cfg.r10) * 61'(s2_uu_q);
      s3_p1_q <= 61'(cfg.r00) * 61'(s2_vv_q);
      s3_p2_q <= 61'(cfg.r01) * 61'(s2_vv_q);
      s3_p3_q <= 61'(cfg.r11) * 61'(s2_uu_q);
      s3_p4_q <= 61'(cfg.tx) * 61'(s2_vv_q);
      s3_p5_q <= 61'(cfg.ty) * 61'(s2_uu_q);
      s3_uu_q <= s2_uu_q;
      s3_in_q <= s2_in_q;

      s4_a_q  <= sat40(64'(s3_p0_q >>> 10) - 64'(s3_p1_q >>> 10));
      s4_b_q  <= sat40(64'(s3_p2_q >>> 10) - 64'(s3_p3_q >>> 10));
      s4_c_q  <= sat40(64'(s3_p4_q >>> 10) - 64'(s3_p5_q >>> 10));
      s4_uu_q <= s3_uu_q;
      s4_in_q <= s3_in_q;

      s5_p0_q <= 61'(cfg.r20) * 61'(s4_c_q);
      s5_p1_q <= 61'(cfg.tz) * 61'(s4_a_q);
      s5_p2_q <= 61'(cfg.r00) * 61'(s4_c_q);
      s5_p3_q <= 61'(cfg.tx) * 61'(s4_a_q);
      s5_p4_q <= 61'(cfg.r00) * 61'(s4_b_q);
      s5_p5_q <= 61'(cfg.r01) * 61'(s4_a_q);
      s5_p6_q <= 61'(cfg.r20) * 61'(s4_b_q);
      s5_p7_q <= 61'(cfg.r21) * 61'(s4_a_q);
      s5_uu_q <= s4_uu_q;
      s5_a_q  <= s4_a_q;
      s5_b_q  <= s4_b_q;
      s5_c_q  <= s4_c_q;
      s5_in_q <= s4_in_q;

      s6_t1_q <= sat40(64'(s5_p0_q >>> 10) + 64'(s5_p1_q >>> 10));
      s6_pn_q <= 53'(64'sd0 - 64'(s5_p2_q >>> 10) - 64'(s5_p3_q >>> 10));
      s6_d1_q <= sat40(64'(s5_p4_q >>> 10) + 64'(s5_p5_q >>> 10));
      s6_d2_q <= sat40(64'(s5_p6_q >>> 10) + 64'(s5_p7_q >>> 10));
      s6_uu_q <= s5_uu_q;
      s6_a_q  <= s5_a_q;
      s6_b_q  <= s5_b_q;
      s6_c_q  <= s5_c_q;
      s6_in_q <= s5_in_q;

      // split the Q.20 products at the binary point of the second operand
      s7_h1_q <= 60'(s6_t1_q) * 60'($signed(s6_uu_q[39:20]));
      s7_l1_q <= 61'(s6_t1_q) * 61'($signed({1'b0, s6_uu_q[19:0]}));
      s7_h2_q <= 60'(s6_uu_q) * 60'($signed(s6_d2_q[39:20]));
      s7_l2_q <= 61'(s6_uu_q) * 61'($signed({1'b0, s6_d2_q[19:0]}));
      s7_pn_q <= s6_pn_q;
      s7_d1_q <= s6_d1_q;
      s7_a_q  <= s6_a_q;
      s7_b_q  <= s6_b_q;
      s7_c_q  <= s6_c_q;
      s7_in_q <= s6_in_q;

      s8_m1_q <= sat40(64'(s7_h1_q) + 64'(s7_l1_q >>> 20));
      s8_m2_q <= sat40(64'(s7_h2_q) + 64'(s7_l2_q >>> 20));
      s8_pn_q <= s7_pn_q;
      s8_d1_q <= s7_d1_q;
      s8_a_q  <= s7_a_q;
      s8_b_q  <= s7_b_q;
      s8_c_q  <= s7_c_q;
      s8_in_q <= s7_in_q;

      s9_num_q <= sat40(64'(s8_m1_q) + 64'(s8_pn_q));
      s9_den_q <= sat40(64'(s8_d1_q) - 64'(s8_m2_q));
      s9_a_q   <= s8_a_q;
      s9_b_q   <= s8_b_q;
      s9_c_q   <= s8_c_q;
      s9_in_q  <= s8_in_q;

      s10_sy_q <= s9_num_q[Q_W-1] ^ s9_den_q[Q_W-1];
      s10_mn_q <= s9_num_q[Q_W-1] ? Q_W'(-s9_num_q) : Q_W'(s9_num_q);
      s10_md_q <= s9_den_q[Q_W-1] ? Q_W'(-s9_den_q) : Q_W'(s9_den_q);
      s10_dg_q <= fzero || (s9_a_q == '0) || (s9_den_q == '0);
      s10_a_q  <= s9_a_q;
      s10_b_q  <= s9_b_q;
      s10_c_q  <= s9_c_q;
      s10_in_q <= s9_in_q;

      s11_y_q  <= div_fix(dvy_side[122], dvy_quo, dvy_ovf);
      s11_dg_q <= dvy_side[121];
      s11_in_q <= dvy_side[120];
      s11_a_q  <= $signed(dvy_side[119:80]);
      s11_b_q  <= $signed(dvy_side[79:40]);
      s11_c_q  <= $signed(dvy_side[39:0]);

      s12_h_q  <= 60'(s11_b_q) * 60'($signed(s11_y_q[39:20]));
      s12_l_q  <= 61'(s11_b_q) * 61'($signed({1'b0, s11_y_q[19:0]}));
      s12_y_q  <= s11_y_q;
      s12_a_q  <= s11_a_q;
      s12_c_q  <= s11_c_q;
      s12_dg_q <= s11_dg_q;
      s12_in_q <= s11_in_q;

      // keep the full product; saturate only after adding c
      s13_m_q  <= 61'(64'(s12_h_q) + 64'(s12_l_q >>> 20));
      s13_y_q  <= s12_y_q;
      s13_a_q  <= s12_a_q;
      s13_c_q  <= s12_c_q;
      s13_dg_q <= s12_dg_q;
      s13_in_q <= s12_in_q;

      s14_e_q  <= sat40(64'(s13_m_q) + 64'(s13_c_q));
      s14_y_q  <= s13_y_q;
      s14_a_q  <= s13_a_q;
      s14_dg_q <= s13_dg_q;
      s14_in_q <= s13_in_q;

      s15_sx_q <= s14_e_q[Q_W-1] ^ s14_a_q[Q_W-1];
      s15_me_q <= s14_e_q[Q_W-1] ? Q_W'(-s14_e_q) : Q_W'(s14_e_q);
      s15_ma_q <= s14_a_q[Q_W-1] ? Q_W'(-s14_a_q) : Q_W'(s14_a_q);
      s15_y_q  <= s14_y_q;
      s15_dg_q <= s14_dg_q;
      s15_in_q <= s14_in_q;

      s16_x_q  <= div_fix(dvx_side[42], dvx_quo, dvx_ovf);
      s16_dg_q <= dvx_side[41];
      s16_in_q <= dvx_side[40];
      s16_y_q  <= $signed(dvx_side[39:0]);

      s17_dr_q  <= hh20 - y41;
      s17_dc_q  <= x41 + hw20;
      s17_px_q  <= trunc_plane(s16_x_q);
      s17_py_q  <= trunc_plane(s16_y_q);
      s17_ins_q <= (x41 > -hw20) && (x41 < hw20) && (y41 > -hh20) && (y41 < hh20) &&
                   s16_in_q && !s16_dg_q;
      s17_dg_q  <= s16_dg_q;

      s18_px_q  <= s17_px_q;
      s18_py_q  <= s17_py_q;
      s18_ins_q <= s17_ins_q;
      s18_dg_q  <= s17_dg_q;

      s19_px_q  <= s18_dg_q ? '0 : s18_px_q;
      s19_py_q  <= s18_dg_q ? '0 : s18_py_q;
      s19_ins_q <= s18_ins_q;
      s19_dg_q  <= s18_dg_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s7_vld_q  <= 1'b0;
      s8_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      s10_vld_q <= 1'b0;
      s11_vld_q <= 1'b0;
      s12_vld_q <= 1'b0;
      s13_vld_q <= 1'b0;
      s14_vld_q <= 1'b0;
      s15_vld_q <= 1'b0;
      s16_vld_q <= 1'b0;
      s17_vld_q <= 1'b0;
      s18_vld_q <= 1'b0;
      s19_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= in_valid_i;
      s2_vld_q  <= dvu_vld;
      s3_vld_q  <= s2_vld_q;
      s4_vld_q  <= s3_vld_q;
      s5_vld_q  <= s4_vld_q;
      s6_vld_q  <= s5_vld_q;
      s7_vld_q  <= s6_vld_q;
      s8_vld_q  <= s7_vld_q;
      s9_vld_q  <= s8_vld_q;
      s10_vld_q <= s9_vld_q;
      s11_vld_q <= dvy_vld;
      s12_vld_q <= s11_vld_q;
      s13_vld_q <= s12_vld_q;
      s14_vld_q <= s13_vld_q;
      s15_vld_q <= s14_vld_q;
      s16_vld_q <= dvx_vld;
      s17_vld_q <= s16_vld_q;
      s18_vld_q <= s17_vld_q;
      s19_vld_q <= s18_vld_q;
    end
  end

  assign out_valid_o    = s19_vld_q;
  assign plane_x_o      = s19_px_q;
  assign plane_y_o      = s19_py_q;
  assign inside_patch_o = s19_ins_q;
  assign texel_row_o    = s19_dg_q ? '0 : tex_row;
  assign texel_col_o    = s19_dg_q ? '0 : tex_col;
  assign degenerate_o   = s19_dg_q;

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(s10_vld_q) && $stable(s16_vld_q))
    else $error("pipeline moved during an output stall");

  a_inside_not_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && inside_patch_o |-> !degenerate_o)
    else $error("inside flag on a degenerate result");

  a_texel_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(texel_row_o) <= 32'(LIM)) && (32'(texel_col_o) <= 32'(LIM)))
    else $error("texel index beyond clamp");

  a_degen_travel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s16_vld_q && in_ready_o && s16_dg_q |=> s17_vld_q && s17_dg_q)
    else $error("degenerate flag lost between stages");

endmodule

// ===== tb/tb_plane_pixel_backprojection.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_plane_pixel_backprojection
// Drives pixel requests under random idling and output stalls, programs the
// pose, intrinsics and patch registers over APB, and checks each result
// field against a bit-accurate fixed-point predictor of the back-projection.
// ----------------------------------------------------------------------------
module tb_plane_pixel_backprojection;
  import ppb_pkg::*;

  localparam int  WATCHDOG_LIMIT = 20000;
  localparam int  DRAIN_CYCLES   = 300;
  localparam longint ONE20       = 64'sd1048576;
  localparam longint Q_HI        = 64'sd549755813887;
  localparam longint Q_LO        = -64'sd549755813888;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [COORD_W-1:0]        pixel_col_i;
  logic [COORD_W-1:0]        pixel_row_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [PLANE_W-1:0] plane_x_o;
  logic signed [PLANE_W-1:0] plane_y_o;
  logic                      inside_patch_o;
  logic [TEX_W-1:0]          texel_row_o;
  logic [TEX_W-1:0]          texel_col_o;
  logic                      degenerate_o;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [APB_AW-1:0]         paddr;
  logic [APB_DW-1:0]         pwdata;
  logic [APB_DW-1:0]         prdata;
  logic                      pready;

  plane_pixel_backprojection u_top (.*);

  typedef struct {
    logic signed [PLANE_W-1:0] px;
    logic signed [PLANE_W-1:0] py;
    logic                      in_patch;
    logic [TEX_W-1:0]          trow;
    logic [TEX_W-1:0]          tcol;
    logic                      degen;
  } texel_hit_t;

  typedef struct {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               typed;
    texel_hit_t         hit;
  } pixel_row_t;

  logic [63:0] regs [8];
  texel_hit_t  pending_hits[$];
  int          mismatches;
  int          checked;
  int          idle_cycles;
  int          accepted_px;
  bit          stall_free;
  bit          drive_en;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---- predictor --------------------------------------------------------
  function automatic longint clip40(longint x);
    if (x > Q_HI) return Q_HI;
    if (x < Q_LO) return Q_LO;
    return x;
  endfunction

  function automatic longint clip21(longint x);
    if (x > 1048575) return 1048575;
    if (x < -1048576) return -1048576;
    return x;
  endfunction

  function automatic longint floor_shr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint pose_word(logic [63:0] r, int pos);
    logic signed [20:0] w;
    w = r[pos +: 21];
    return longint'(w);
  endfunction

  function automatic longint pose_mul(longint p, longint x);
    return floor_shr(p * x, 10);
  endfunction

  function automatic longint q20_mul(longint x, longint y);
    longint yh;
    longint yl;
    yh = floor_shr(y, 20);
    yl = y - yh * ONE20;
    return x * yh + floor_shr(x * yl, 20);
  endfunction

  // wide divide, truncating toward zero
  function automatic longint div_trunc(logic signed [127:0] n, longint d);
    logic signed [127:0] q;
    q = n / 128'(signed'(d));
    if (q > 128'(Q_HI)) return Q_HI;
    if (q < 128'(Q_LO)) return Q_LO;
    return longint'(q);
  endfunction

  function automatic logic [TEX_W-1:0] texel_of(longint len, longint tpu);
    logic [63:0] d;
    logic [63:0] q;
    if (len <= 0) return '0;
    d = len;
    q = ((d >> 20) * tpu + (((d & 64'hFFFFF) * tpu) >> 20)) >> 16;
    return (q > 1023) ? 10'd1023 : q[9:0];
  endfunction

  function automatic texel_hit_t backproject(logic [COORD_W-1:0] ucol,
                                             logic [COORD_W-1:0] vrow);
    texel_hit_t h;
    longint fx, fy, cx, cy, r00, r01, tx, r10, r11, ty, r20, r21, tz;
    longint uu, vv, a, b, c, t1, num, d1, d2, den, y20, x20, hw20, hh20;
    h = '{default: '0};
    h.degen = 1'b1;
    fx  = regs[REG_FOCAL][61:31];
    fy  = regs[REG_FOCAL][30:0];
    cx  = regs[REG_PRINCIPAL][61:31];
    cy  = regs[REG_PRINCIPAL][30:0];
    r00 = pose_word(regs[REG_ROW_X], 42);
    r01 = pose_word(regs[REG_ROW_X], 21);
    tx  = pose_word(regs[REG_ROW_X], 0);
    r10 = pose_word(regs[REG_ROW_Y], 42);
    r11 = pose_word(regs[REG_ROW_Y], 21);
    ty  = pose_word(regs[REG_ROW_Y], 0);
    r20 = pose_word(regs[REG_ROW_W], 42);
    r21 = pose_word(regs[REG_ROW_W], 21);
    tz  = pose_word(regs[REG_ROW_W], 0);
    if (fx == 0 || fy == 0) return h;
    uu = div_trunc(128'(longint'(ucol) * ONE20 - cx) * 128'(ONE20), fx);
    vv = div_trunc(128'(longint'(vrow) * ONE20 - cy) * 128'(ONE20), fy);
    a  = clip40(pose_mul(r10, uu) - pose_mul(r00, vv));
    b  = clip40(pose_mul(r01, vv) - pose_mul(r11, uu));
    c  = clip40(pose_mul(tx, vv) - pose_mul(ty, uu));
    t1 = clip40(pose_mul(r20, c) + pose_mul(tz, a));
    num = clip40(clip40(q20_mul(t1, uu)) - pose_mul(r00, c) - pose_mul(tx, a));
    d1 = clip40(pose_mul(r00, b) + pose_mul(r01, a));
    d2 = clip40(pose_mul(r20, b) + pose_mul(r21, a));
    den = clip40(d1 - clip40(q20_mul(uu, d2)));
    if (a == 0 || den == 0) return h;
    y20 = div_trunc(128'(num) * 128'(ONE20), den);
    x20 = div_trunc(128'(clip40(q20_mul(b, y20) + c)) * 128'(ONE20), a);
    hw20 = longint'(regs[REG_HALF_W][19:0]) * 4096;
    hh20 = longint'(regs[REG_HALF_H][19:0]) * 4096;
    h.degen    = 1'b0;
    h.in_patch = x20 > -hw20 && x20 < hw20 && y20 > -hh20 && y20 < hh20 &&
                 ucol < IMAGE_DIM_DEF && vrow < IMAGE_DIM_DEF;
    h.px   = 21'(clip21(x20 / 4096));
    h.py   = 21'(clip21(y20 / 4096));
    h.trow = texel_of(hh20 - y20, longint'(regs[REG_TPU][23:0]));
    h.tcol = texel_of(x20 + hw20, longint'(regs[REG_TPU][23:0]));
    return h;
  endfunction

  // ---- checking ---------------------------------------------------------
  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t mismatch %s: got %0d want %0d", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin
    texel_hit_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_hits.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = pending_hits.pop_front();
        checked++;
        if (plane_x_o !== want.px) report_mismatch("plane_x", plane_x_o, want.px);
        if (plane_y_o !== want.py) report_mismatch("plane_y", plane_y_o, want.py);
        if (inside_patch_o !== want.in_patch)
          report_mismatch("inside_patch", inside_patch_o, want.in_patch);
        if (texel_row_o !== want.trow) report_mismatch("texel_row", texel_row_o, want.trow);
        if (texel_col_o !== want.tcol) report_mismatch("texel_col", texel_col_o, want.tcol);
        if (degenerate_o !== want.degen)
          report_mismatch("degenerate", degenerate_o, want.degen);
      end
    end
  end

  // result-side stall
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= stall_free || ($urandom_range(99) >= 29);
    end
  end

  // watchdog: cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !drive_en)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("plane_pixel_backprojection verification failed");
      $finish;
    end
  end

  // ---- stimulus ---------------------------------------------------------
  task automatic write_reg(reg_idx_e idx, logic [63:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(8 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ROW_X, REG_ROW_Y, REG_ROW_W: regs[idx] = value & 64'h7FFF_FFFF_FFFF_FFFF;
      REG_FOCAL, REG_PRINCIPAL:        regs[idx] = value & 64'h3FFF_FFFF_FFFF_FFFF;
      REG_HALF_W, REG_HALF_H:          regs[idx] = value & 64'hFFFFF;
      default:                         regs[idx] = value & 64'hFFFFFF;
    endcase
  endtask

  // send one pixel; idle at random first, then hold until accepted.
  // valid stays high after the accept; the next request or an idle cycle
  // replaces it in the same time step
  task automatic send_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                            bit typed, texel_hit_t typed_hit);
    texel_hit_t h;
    while (!stall_free && $urandom_range(99) < 29) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    h = typed ? typed_hit : backproject(col, row);
    in_valid_i  <= 1'b1;
    pixel_col_i <= col;
    pixel_row_i <= row;
    do @(posedge clk_i); while (!in_ready_o);
    pending_hits.insert(pending_hits.size(), h);
    accepted_px++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [20:0] pose_q(real v);
    return 21'($rtoi(v * 1024.0));
  endfunction

  task automatic load_camera(real s, real tz_v, real fpix, real cx_v, real cy_v);
    logic [30:0] f;
    logic [30:0] cxq;
    logic [30:0] cyq;
    f   = 31'($rtoi(fpix * 1048576.0));
    cxq = 31'($rtoi(cx_v * 1048576.0));
    cyq = 31'($rtoi(cy_v * 1048576.0));
    // scaled pose with small cross terms so every term is exercised
    write_reg(REG_ROW_X, {pose_q(s), pose_q(0.05), pose_q(3.0)});
    write_reg(REG_ROW_Y, {pose_q(0.02), pose_q(-s), pose_q(-2.0)});
    write_reg(REG_ROW_W, {pose_q(0.1), pose_q(-0.2), pose_q(tz_v)});
    write_reg(REG_FOCAL, {f, f});
    write_reg(REG_PRINCIPAL, {cxq, cyq});
  endtask

  initial begin
    pixel_row_t directed[$];
    texel_hit_t zero_degen;
    texel_hit_t dummy;
    int phase;
    int n;
    logic [COORD_W-1:0] c0;
    logic [COORD_W-1:0] r0;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    pixel_col_i = '0;
    pixel_row_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    checked = 0;
    accepted_px = 0;
    idle_cycles = 0;
    stall_free = 1'b0;
    drive_en = 1'b0;
    regs[REG_ROW_X] = 0;
    regs[REG_ROW_Y] = 0;
    regs[REG_ROW_W] = 0;
    regs[REG_FOCAL] = 0;
    regs[REG_PRINCIPAL] = 0;
    regs[REG_HALF_W] = 32000;
    regs[REG_HALF_H] = 32000;
    regs[REG_TPU] = 65536;
    zero_degen = '{default: '0};
    zero_degen.degen = 1'b1;
    dummy = zero_degen;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    drive_en = 1'b1;

    // after reset the focal lengths are zero: every pixel is degenerate
    directed.insert(directed.size(), pixel_row_t'{11'd0, 11'd0, 1'b1, zero_degen});
    directed.insert(directed.size(), pixel_row_t'{11'd2047, 11'd2047, 1'b1, zero_degen});
    directed.insert(directed.size(), pixel_row_t'{11'd1024, 11'd5, 1'b1, zero_degen});
    foreach (directed[i]) send_pixel(directed[i].col, directed[i].row, 1'b1, directed[i].hit);
    drain();

    // typical camera; corners, centre, pixels at the image edge
    load_camera(1.0, 40.0, 800.0, 1023.5, 1023.5);
    directed.delete();
    directed.insert(directed.size(), pixel_row_t'{11'd0, 11'd0, 1'b0, dummy});
    directed.insert(directed.size(), pixel_row_t'{11'd2047, 11'd0, 1'b0, dummy});
    directed.insert(directed.size(), pixel_row_t'{11'd0, 11'd2047, 1'b0, dummy});
    directed.insert(directed.size(), pixel_row_t'{11'd2047, 11'd2047, 1'b0, dummy});
    directed.insert(directed.size(), pixel_row_t'{11'd1024, 11'd1024, 1'b0, dummy});
    directed.insert(directed.size(), pixel_row_t'{11'd1000, 11'd1050, 1'b0, dummy});
    directed.insert(directed.size(), pixel_row_t'{11'd1365, 11'd682, 1'b0, dummy});
    directed.insert(directed.size(), pixel_row_t'{11'd682, 11'd1365, 1'b0, dummy});
    foreach (directed[i]) send_pixel(directed[i].col, directed[i].row, 1'b0, dummy);
    drain();

    // zero pose with nonzero focal: a is zero, degenerate
    write_reg(REG_ROW_X, '0);
    write_reg(REG_ROW_Y, '0);
    write_reg(REG_ROW_W, '0);
    send_pixel(11'd10, 11'd20, 1'b1, zero_degen);
    send_pixel(11'd2047, 11'd1, 1'b1, zero_degen);
    drain();

    // random phases; extreme values of several registers come up along the way
    for (phase = 0; phase < 12; phase++) begin
      stall_free = (phase == 5);
      case (phase % 4)
        0: load_camera(1.0, 30.0 + phase, 600.0 + 50.0 * phase, 1023.5, 1023.5);
        1: load_camera(0.5, 10.0, 2047.0, 0.0, 2047.0);
        2: begin
          write_reg(REG_ROW_X, {$urandom, $urandom});
          write_reg(REG_ROW_Y, {$urandom, $urandom});
          write_reg(REG_ROW_W, {$urandom, $urandom});
          write_reg(REG_FOCAL, {$urandom, $urandom} | 64'h1_0000_0001);
          write_reg(REG_PRINCIPAL, {$urandom, $urandom});
        end
        default: begin
          write_reg(REG_ROW_X, 64'h7FFF_FFFF_FFFF_FFFF);
          write_reg(REG_ROW_Y, 64'h4000_0200_0010_0000);
          write_reg(REG_ROW_W, 64'h1555_5555_5555_5555);
          write_reg(REG_FOCAL, 64'h0000_0000_8000_0001);
          write_reg(REG_PRINCIPAL, 64'h3FFF_FFFF_FFFF_FFFF);
        end
      endcase
      case (phase % 3)
        0: begin
          write_reg(REG_HALF_W, 64'(32000 + phase * 1000));
          write_reg(REG_HALF_H, 64'(20000 + phase * 3000));
          write_reg(REG_TPU, 64'(65536 << (phase % 3)));
        end
        1: begin
          write_reg(REG_HALF_W, 64'hFFFFF);
          write_reg(REG_HALF_H, 64'd0);
          write_reg(REG_TPU, 64'hFFFFFF);
        end
        default: begin
          write_reg(REG_HALF_W, 64'd0);
          write_reg(REG_HALF_H, 64'hFFFFF);
          write_reg(REG_TPU, 64'($urandom_range(24'hFFFFFF)));
        end
      endcase
      n = 140;
      c0 = COORD_W'($urandom_range(1900));
      r0 = COORD_W'($urandom_range(2047));
      for (int k = 0; k < n; k++) begin
        // mostly short raster runs, some scattered pixels
        if ($urandom_range(99) < 70)
          send_pixel(c0 + COORD_W'(k % 64), r0 + COORD_W'(k / 64), 1'b0, dummy);
        else
          send_pixel(COORD_W'($urandom), COORD_W'($urandom), 1'b0, dummy);
      end
      drain();
    end
    stall_free = 1'b0;

    $display("covered %0d pixel requests, %0d results checked, 15 register settings",
             accepted_px, checked);
    if (mismatches == 0) begin
      $display("plane_pixel_backprojection verification clean");
    end else begin
      $display("plane_pixel_backprojection verification failed");
    end
    $finish;
  end

endmodule
